// ===== design/sycc_pkg.sv =====
// Package: shared types, constants and arithmetic helpers for the sYCC to RGB block.
`default_nettype none
package sycc_pkg;

   // Configuration register indexes.
   localparam logic CSR_PRECISION = 1'b0;
   localparam logic CSR_MODE      = 1'b1;
   localparam int   CSR_IDX_W     = 1;
   localparam int   CSR_DATA_W    = 5;

   // Chroma sharing modes.
   localparam logic [1:0] MODE_444 = 2'd0;
   localparam logic [1:0] MODE_422 = 2'd1;

   // Group positions of the last result for each mode.
   localparam logic [1:0] POS_LAST_444 = 2'd0;
   localparam logic [1:0] POS_LAST_422 = 2'd1;
   localparam logic [1:0] POS_LAST_420 = 2'd3;

   localparam logic [4:0] PREC_RESET = 5'd8;
   localparam logic [4:0] PREC_MIN   = 5'd1;
   localparam logic [4:0] PREC_MAX   = 5'd16;

   localparam int SAMPLE_W = 16;
   localparam int LANES    = 4;
   localparam int PROD_W   = 35;
   localparam int SUM_W    = 36;
   localparam int TERM_W   = 19;
   localparam int LANE_W   = 21;

   // Q16 coefficients.
   localparam logic signed [PROD_W-1:0] COEF_CR_R = 35'sd91881;
   localparam logic signed [PROD_W-1:0] COEF_CB_G = 35'sd22544;
   localparam logic signed [PROD_W-1:0] COEF_CR_G = 35'sd46793;
   localparam logic signed [PROD_W-1:0] COEF_CB_B = 35'sd116130;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // Per-item control that travels with the data.
   typedef struct packed {
      logic [1:0] last_pos;
      sample_type upb;
   } meta_type;

   // Correction terms shared by all lanes of one item.
   typedef struct packed {
      logic signed [TERM_W-1:0] tr;
      logic signed [TERM_W-1:0] tg;
      logic signed [TERM_W-1:0] tb;
   } term_type;

   typedef struct packed {
      sample_type red;
      sample_type green;
      sample_type blue;
   } pixel_type;

   // Precision limited to 1..16.
   function automatic logic [4:0] eff_prec(input logic [4:0] p);
      logic [4:0] r;
      r = p;
      if (p < PREC_MIN) r = PREC_MIN;
      if (p > PREC_MAX) r = PREC_MAX;
      return r;
   endfunction

   // Position of the last result in a group.
   function automatic logic [1:0] last_pos_of(input logic [1:0] mode);
      logic [1:0] r;
      case (mode)
         MODE_444: r = POS_LAST_444;
         MODE_422: r = POS_LAST_422;
         default:  r = POS_LAST_420;
      endcase
      return r;
   endfunction

   // Divide by 2^16, truncating toward zero.
   function automatic logic signed [TERM_W-1:0] trunc_q16(input logic signed [SUM_W-1:0] p);
      logic signed [SUM_W-1:0] b;
      b = p + (p[SUM_W-1] ? 36'sd65535 : 36'sd0);
      return TERM_W'(b >>> 16);
   endfunction

   // Clamp a signed sum to 0..upb.
   function automatic sample_type clamp_to(input logic signed [LANE_W-1:0] v,
                                           input sample_type upb);
      sample_type r;
      if (v[LANE_W-1]) r = '0;
      else if (v > $signed({5'b0, upb})) r = upb;
      else r = v[SAMPLE_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/sycc_req_if.sv =====
// Interface: input channel carrying one chroma pair and four luma samples.
`default_nettype none
interface sycc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] luma_top_left;
   logic [15:0] luma_top_right;
   logic [15:0] luma_bottom_left;
   logic [15:0] luma_bottom_right;
   logic [15:0] chroma_blue;
   logic [15:0] chroma_red;

   modport source (output valid, luma_top_left, luma_top_right, luma_bottom_left,
                   luma_bottom_right, chroma_blue, chroma_red, input ready);
   modport sink   (input valid, luma_top_left, luma_top_right, luma_bottom_left,
                   luma_bottom_right, chroma_blue, chroma_red, output ready);
endinterface
`default_nettype wire

// ===== design/sycc_rsp_if.sv =====
// Interface: result channel carrying one RGB pixel and its group position.
`default_nettype none
interface sycc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;
   logic [1:0]  group_position;
   logic        last_of_group;

   modport source (output valid, red, green, blue, group_position, last_of_group,
                   input ready);
   modport sink   (input valid, red, green, blue, group_position, last_of_group,
                   output ready);
endinterface
`default_nettype wire

// ===== design/sycc_chroma.sv =====
// Chroma path: centring, coefficient products and truncated correction terms.
`default_nettype none
module sycc_chroma (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    en,
   input  wire logic                                    in_valid,
   input  wire sycc_pkg::sample_type                    cb_in,
   input  wire sycc_pkg::sample_type                    cr_in,
   input  wire logic [sycc_pkg::LANES-1:0][15:0]        luma_in,
   input  wire logic [4:0]                              prec,
   input  wire logic [1:0]                              mode,
   output logic                                         out_valid,
   output sycc_pkg::term_type                           terms,
   output sycc_pkg::meta_type                           meta,
   output logic [sycc_pkg::LANES-1:0][15:0]             luma_out
);
   import sycc_pkg::*;

   logic [4:0]  p_eff;
   sample_type  offset;
   logic [16:0] upb_wide;
   meta_type    meta_in;

   logic                            v1_ff, v2_ff, v3_ff;
   logic signed [16:0]              cb1_ff, cr1_ff;
   meta_type                        meta1_ff, meta2_ff, meta3_ff;
   logic [LANES-1:0][15:0]          luma1_ff, luma2_ff, luma3_ff;
   logic signed [PROD_W-1:0]        pr2_ff, pgb2_ff, pgr2_ff, pb2_ff;
   term_type                        terms3_ff;
   logic signed [SUM_W-1:0]         g_sum;

   // Item-wide constants from the precision register.
   always_comb begin
      p_eff    = eff_prec(prec);
      offset   = SAMPLE_W'(17'd1 << (p_eff - 5'd1));
      upb_wide = (17'd1 << p_eff) - 17'd1;
      meta_in.upb      = upb_wide[SAMPLE_W-1:0];
      meta_in.last_pos = last_pos_of(mode);
   end

   // Stage valid bits move together under the pipeline enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage 1 centres chroma, stage 2 forms products, stage 3 truncates.
   assign g_sum = SUM_W'(pgb2_ff) + SUM_W'(pgr2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         cb1_ff    <= $signed({1'b0, cb_in}) - $signed({1'b0, offset});
         cr1_ff    <= $signed({1'b0, cr_in}) - $signed({1'b0, offset});
         meta1_ff  <= meta_in;
         luma1_ff  <= luma_in;
         pr2_ff    <= COEF_CR_R * PROD_W'(cr1_ff);
         pgb2_ff   <= COEF_CB_G * PROD_W'(cb1_ff);
         pgr2_ff   <= COEF_CR_G * PROD_W'(cr1_ff);
         pb2_ff    <= COEF_CB_B * PROD_W'(cb1_ff);
         meta2_ff  <= meta1_ff;
         luma2_ff  <= luma1_ff;
         terms3_ff.tr <= trunc_q16(SUM_W'(pr2_ff));
         terms3_ff.tg <= trunc_q16(g_sum);
         terms3_ff.tb <= trunc_q16(SUM_W'(pb2_ff));
         meta3_ff  <= meta2_ff;
         luma3_ff  <= luma2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign terms     = terms3_ff;
   assign meta      = meta3_ff;
   assign luma_out  = luma3_ff;

endmodule
`default_nettype wire

// ===== design/sycc_lane.sv =====
// One conversion lane: adds the shared terms to one luma sample and clamps.
`default_nettype none
module sycc_lane (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire sycc_pkg::sample_type luma,
   input  wire sycc_pkg::term_type   terms,
   input  wire sycc_pkg::sample_type upb,
   output sycc_pkg::pixel_type       pixel
);
   import sycc_pkg::*;

   logic signed [LANE_W-1:0] y, sum_r, sum_g, sum_b;
   pixel_type                pixel_ff;

   // Signed sums for the three components.
   always_comb begin
      y     = $signed({5'b0, luma});
      sum_r = y + LANE_W'(terms.tr);
      sum_g = y - LANE_W'(terms.tg);
      sum_b = y + LANE_W'(terms.tb);
   end

   // Clamped components are registered.
   always_ff @(posedge clock) begin
      if (en) begin
         pixel_ff.red   <= clamp_to(sum_r, upb);
         pixel_ff.green <= clamp_to(sum_g, upb);
         pixel_ff.blue  <= clamp_to(sum_b, upb);
      end
   end

   assign pixel = pixel_ff;

endmodule
`default_nettype wire

// ===== design/sycc_merge.sv =====
// Merge stage: holds a group's lane results, sends one per cycle unless stalled.
`default_nettype none
module sycc_merge (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire sycc_pkg::pixel_type [sycc_pkg::LANES-1:0] pixels,
   input  wire sycc_pkg::meta_type                     meta,
   output logic                                        buf_free,
   sycc_rsp_if.source                                  rsp_chan
);
   import sycc_pkg::*;

   logic                       buf_valid_ff, buf_valid_in;
   logic [1:0]                 idx_ff, idx_in;
   logic [1:0]                 last_pos_ff, last_pos_in;
   pixel_type [LANES-1:0]      pix_ff;
   logic                       fire, is_last, load;

   assign is_last  = (idx_ff == last_pos_ff);
   assign fire     = buf_valid_ff && rsp_chan.ready;
   assign buf_free = !buf_valid_ff || (fire && is_last);
   assign load     = in_valid && buf_free;

   // Position counter walks through the group; a new group loads when free.
   always_comb begin
      buf_valid_in = buf_valid_ff;
      idx_in       = idx_ff;
      last_pos_in  = last_pos_ff;
      if (load) begin
         buf_valid_in = 1'b1;
         idx_in       = 2'd0;
         last_pos_in  = meta.last_pos;
      end else if (fire) begin
         if (is_last) buf_valid_in = 1'b0;
         else idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         last_pos_ff  <= POS_LAST_444;
      end else begin
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
         last_pos_ff  <= last_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) pix_ff <= pixels;
   end

   // Result transaction fields.
   assign rsp_chan.valid          = buf_valid_ff;
   assign rsp_chan.red            = pix_ff[idx_ff].red;
   assign rsp_chan.green          = pix_ff[idx_ff].green;
   assign rsp_chan.blue           = pix_ff[idx_ff].blue;
   assign rsp_chan.group_position = idx_ff;
   assign rsp_chan.last_of_group  = is_last;

   // The position never passes the end of its group.
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (idx_ff <= last_pos_ff))
      else $error("group position beyond last result");

   // Group length is one, two or four results.
   a_last_pos_legal: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (last_pos_ff == POS_LAST_444 || last_pos_ff == POS_LAST_422 ||
                        last_pos_ff == POS_LAST_420))
      else $error("illegal group length");

   // A taken result that is not the last moves to the next position.
   a_idx_advance: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_last) |=> (buf_valid_ff && idx_ff == $past(idx_ff) + 2'd1))
      else $error("group position did not advance");

   // A stalled group keeps its position.
   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      (buf_valid_ff && !rsp_chan.ready) |=> (buf_valid_ff && $stable(idx_ff)))
      else $error("group position changed under stall");

endmodule
`default_nettype wire

// ===== design/sycc_to_rgb_upsample_convert.sv =====
// Top level: sYCC to RGB conversion with 4:4:4, 4:2:2 and 4:2:0 chroma sharing.
//
//   Channel   Direction  Carries
//   req_chan  in         one chroma pair and four luma samples per transaction
//   rsp_chan  out        one clamped RGB pixel, group position and last marker
//   csr_*     in         writes of sample_precision (0) and subsampling_mode (1)
//
// An item passes four register stages (centring, products, truncation, lanes)
// before its group is loaded into the merge buffer.
// The merge buffer sends one result per cycle while rsp_chan is ready; an item
// yields 1, 2 or 4 results (4:4:4, 4:2:2, 4:2:0); one result port sets this rate.
// Reset is synchronous and active high; it empties the pipeline and loads
// precision 8 and mode 4:4:4. A stall on rsp_chan stops the pipeline once the
// buffer holds a waiting group with a full stage behind it.
`default_nettype none
module sycc_to_rgb_upsample_convert (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sycc_req_if.sink                              req_chan,
   sycc_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [sycc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sycc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sycc_pkg::*;

   logic [4:0]              prec_ff;
   logic [1:0]              mode_ff;
   logic                    adv, buf_free, c_valid, v4_ff;
   term_type                terms;
   meta_type                c_meta, meta4_ff;
   logic [LANES-1:0][15:0]  luma_in, luma_c;
   pixel_type [LANES-1:0]   pixels;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff <= PREC_RESET;
         mode_ff <= MODE_444;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PRECISION: prec_ff <= csr_wdata;
            CSR_MODE:      mode_ff <= csr_wdata[1:0];
            default:       prec_ff <= prec_ff;
         endcase
      end
   end

   // The pipeline moves whenever the lane stage is empty or can hand over.
   assign adv            = !v4_ff || buf_free;
   assign req_chan.ready = adv;

   assign luma_in[0] = req_chan.luma_top_left;
   assign luma_in[1] = req_chan.luma_top_right;
   assign luma_in[2] = req_chan.luma_bottom_left;
   assign luma_in[3] = req_chan.luma_bottom_right;

   sycc_chroma u_chroma (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_chan.valid),
      .cb_in     (req_chan.chroma_blue),
      .cr_in     (req_chan.chroma_red),
      .luma_in   (luma_in),
      .prec      (prec_ff),
      .mode      (mode_ff),
      .out_valid (c_valid),
      .terms     (terms),
      .meta      (c_meta),
      .luma_out  (luma_c)
   );

   // Four lanes convert all luma samples of a group side by side.
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      sycc_lane u_lane (
         .clock (clock),
         .en    (adv),
         .luma  (luma_c[i]),
         .terms (terms),
         .upb   (c_meta.upb),
         .pixel (pixels[i])
      );
   end

   // Lane stage valid and group control.
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) meta4_ff <= c_meta;
   end

   sycc_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .pixels   (pixels),
      .meta     (meta4_ff),
      .buf_free (buf_free),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the sYCC to RGB block: directed and random transactions checked per pixel.
`timescale 1ns / 100ps

module testbench;
   import sycc_pkg::*;

   // Mode codes that the package does not name.
   localparam logic [1:0] MODE_420  = 2'd2;
   localparam logic [1:0] MODE_RSVD = 2'd3;

   // Q16 coefficients of the conversion.
   localparam longint Q16_CR_TO_R = 91881;
   localparam longint Q16_CB_TO_G = 22544;
   localparam longint Q16_CR_TO_G = 46793;
   localparam longint Q16_CB_TO_B = 116130;

   // Cycles to wait after the last pixel before the block counts as idle.
   localparam int SETTLE_CYCLES = 10;
   localparam int MAX_REPORTS   = 10;

   // One input transaction: four luma samples and one chroma pair.
   typedef struct packed {
      logic [15:0] luma_tl;
      logic [15:0] luma_tr;
      logic [15:0] luma_bl;
      logic [15:0] luma_br;
      logic [15:0] chroma_b;
      logic [15:0] chroma_r;
   } sycc_group_type;

   // One expected output pixel.
   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [1:0]  position;
      logic        last;
   } rgb_pixel_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sycc_req_if req_bus ();
   sycc_rsp_if rsp_bus ();

   // Shadow copies of the configuration registers.
   logic [4:0] shadow_precision;
   logic [1:0] shadow_mode;

   rgb_pixel_type pending_pixels[$];
   rgb_pixel_type oldest_pixel;
   int            mismatch_count = 0;
   int            send_idle_pct  = 0;
   int            rsp_stall_pct  = 0;

   sycc_to_rgb_upsample_convert u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Precision limited to the range that the block supports.
   function automatic int unsigned effective_precision(input logic [4:0] prec);
      int unsigned p;
      p = prec;
      if (p < 1) p = 1;
      if (p > 16) p = 16;
      return p;
   endfunction

   // Divide by 2^16, truncating toward zero.
   function automatic longint q16_toward_zero(input longint prod);
      if (prod < 0) return -((-prod) >>> 16);
      return prod >>> 16;
   endfunction

   function automatic logic [15:0] clamp_component(input longint v, input longint ceiling);
      if (v < 0) return 16'd0;
      if (v > ceiling) return ceiling[15:0];
      return v[15:0];
   endfunction

   // Work out the pixels that one accepted group produces and queue them.
   function automatic void predict_pixels(input sycc_group_type g);
      int unsigned prec;
      longint offset, ceiling, cb, cr, term_r, term_g, term_b, y;
      int count;
      logic [15:0] luma[4];
      rgb_pixel_type px;
      prec    = effective_precision(shadow_precision);
      offset  = longint'(1) << (prec - 1);
      ceiling = (longint'(1) << prec) - 1;
      cb      = longint'(g.chroma_b) - offset;
      cr      = longint'(g.chroma_r) - offset;
      term_r  = q16_toward_zero(Q16_CR_TO_R * cr);
      term_g  = q16_toward_zero(Q16_CB_TO_G * cb + Q16_CR_TO_G * cr);
      term_b  = q16_toward_zero(Q16_CB_TO_B * cb);
      luma[0] = g.luma_tl;
      luma[1] = g.luma_tr;
      luma[2] = g.luma_bl;
      luma[3] = g.luma_br;
      case (shadow_mode)
         MODE_444: count = 1;
         MODE_422: count = 2;
         default:  count = 4;
      endcase
      for (int k = 0; k < count; k++) begin
         y           = longint'(luma[k]);
         px.red      = clamp_component(y + term_r, ceiling);
         px.green    = clamp_component(y - term_g, ceiling);
         px.blue     = clamp_component(y + term_b, ceiling);
         px.position = k[1:0];
         px.last     = (k == count - 1);
         pending_pixels.push_back(px);
      end
   endfunction

   // Result channel backpressure, changed at the falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare every accepted pixel with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: unexpected pixel r=%h g=%h b=%h pos=%0d last=%0b", $realtime,
                        rsp_bus.red, rsp_bus.green, rsp_bus.blue, rsp_bus.group_position,
                        rsp_bus.last_of_group);
            mismatch_count++;
         end else begin
            oldest_pixel = pending_pixels.pop_front();
            if (rsp_bus.red !== oldest_pixel.red || rsp_bus.green !== oldest_pixel.green ||
                rsp_bus.blue !== oldest_pixel.blue ||
                rsp_bus.group_position !== oldest_pixel.position ||
                rsp_bus.last_of_group !== oldest_pixel.last) begin
               if (mismatch_count < MAX_REPORTS)
                  $display({"%0t: pixel mismatch expected r=%h g=%h b=%h pos=%0d last=%0b,",
                            " got r=%h g=%h b=%h pos=%0d last=%0b"},
                           $realtime, oldest_pixel.red, oldest_pixel.green, oldest_pixel.blue,
                           oldest_pixel.position, oldest_pixel.last, rsp_bus.red,
                           rsp_bus.green, rsp_bus.blue, rsp_bus.group_position,
                           rsp_bus.last_of_group);
               mismatch_count++;
            end
         end
      end
   end

   // Write one configuration register; called at a falling edge while the block is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [4:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PRECISION) shadow_precision = value;
      else shadow_mode = value[1:0];
      @(negedge clock);
   endtask

   task automatic configure(input logic [4:0] prec, input logic [1:0] mode);
      write_csr(CSR_PRECISION, prec);
      write_csr(CSR_MODE, {3'($urandom_range(7)), mode});
   endtask

   // Send one transaction, with random idle cycles ahead of it.
   task automatic send_group(input sycc_group_type g);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.luma_top_left     <= g.luma_tl;
      req_bus.luma_top_right    <= g.luma_tr;
      req_bus.luma_bottom_left  <= g.luma_bl;
      req_bus.luma_bottom_right <= g.luma_br;
      req_bus.chroma_blue       <= g.chroma_b;
      req_bus.chroma_red        <= g.chroma_r;
      do @(posedge clock); while (!req_bus.ready);
      predict_pixels(g);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [15:0] tl, input logic [15:0] tr,
                              input logic [15:0] bl, input logic [15:0] br,
                              input logic [15:0] cb, input logic [15:0] cr);
      send_group('{luma_tl: tl, luma_tr: tr, luma_bl: bl, luma_br: br,
                   chroma_b: cb, chroma_r: cr});
   endtask

   // Stop sending and wait until every expected pixel has arrived and the pipe is empty.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random sample: mostly inside the precision range, sometimes any 16-bit value.
   function automatic logic [15:0] rand_sample(input logic [4:0] prec);
      int unsigned p;
      logic [15:0] ceiling;
      p       = effective_precision(prec);
      ceiling = 16'((32'd1 << p) - 1);
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return ceiling;
         2:       return 16'(32'd1 << (p - 1));
         3, 4:    return 16'($urandom);
         default: return 16'($urandom) & ceiling;
      endcase
   endfunction

   // Reset values: precision 8, 4:4:4, with no configuration written.
   task automatic test_reset_defaults();
      send_fields(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
      send_fields(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_fields(16'h0080, 16'h1234, 16'h5678, 16'h9ABC, 16'h0080, 16'h0080);
      send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      wait_drained();
   endtask

   // Modes 4:2:2, 4:2:0 and the reserved one, with extreme samples.
   task automatic test_mode_extremes();
      configure(5'd16, MODE_422);
      send_fields(16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h0000, 16'h0000);
      send_fields(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_fields(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000);
      wait_drained();
      configure(5'd1, MODE_420);
      send_fields(16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0000, 16'h0001);
      send_fields(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0000);
      send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
      wait_drained();
      configure(5'd12, MODE_RSVD);
      send_fields(16'h0000, 16'h0FFF, 16'h0800, 16'hFFFF, 16'h0800, 16'h0000);
      send_fields(16'h0123, 16'h0456, 16'h0789, 16'h0ABC, 16'h0FFF, 16'h0FFF);
      wait_drained();
   endtask

   // Precision zero and precision above sixteen, and samples wider than the precision.
   task automatic test_precision_limits();
      configure(5'd0, MODE_444);
      send_fields(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
      send_fields(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001);
      wait_drained();
      configure(5'd31, MODE_422);
      send_fields(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_fields(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
      wait_drained();
      configure(5'd17, MODE_420);
      send_fields(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF);
      wait_drained();
      configure(5'd10, MODE_444);
      send_fields(16'hF3FF, 16'h0000, 16'h0000, 16'h0000, 16'hFC00, 16'h0400);
      wait_drained();
   endtask

   // Random groups over several configurations, with the given idle and stall rates.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_groups);
      logic [4:0] prec;
      logic [1:0] mode;
      sycc_group_type g;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int b = 0; b < 4; b++) begin
         case ($urandom_range(7))
            0:       prec = 5'd1;
            1:       prec = 5'd16;
            2:       prec = 5'd8;
            3:       prec = 5'd0;
            4:       prec = 5'($urandom_range(31));
            default: prec = 5'($urandom_range(16, 1));
         endcase
         mode = 2'($urandom_range(3));
         configure(prec, mode);
         for (int i = 0; i < n_groups / 4; i++) begin
            g.luma_tl  = rand_sample(prec);
            g.luma_tr  = rand_sample(prec);
            g.luma_bl  = rand_sample(prec);
            g.luma_br  = rand_sample(prec);
            g.chroma_b = rand_sample(prec);
            g.chroma_r = rand_sample(prec);
            send_group(g);
         end
         wait_drained();
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // Run limit.
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Test sequence.
   initial begin
      reset                     = 1'b1;
      csr_we                    = 1'b0;
      csr_index                 = '0;
      csr_wdata                 = '0;
      req_bus.valid             = 1'b0;
      req_bus.luma_top_left     = '0;
      req_bus.luma_top_right    = '0;
      req_bus.luma_bottom_left  = '0;
      req_bus.luma_bottom_right = '0;
      req_bus.chroma_blue       = '0;
      req_bus.chroma_red        = '0;
      rsp_bus.ready             = 1'b0;
      shadow_precision          = PREC_RESET;
      shadow_mode               = MODE_444;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_mode_extremes();
      test_precision_limits();
      test_random_traffic(0, 0, 64);
      test_random_traffic(57, 0, 64);
      test_random_traffic(0, 57, 64);
      test_random_traffic(29, 29, 64);

      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sycc_to_rgb_upsample_convert.f =====
design/sycc_pkg.sv
design/sycc_req_if.sv
design/sycc_rsp_if.sv
design/sycc_chroma.sv
design/sycc_lane.sv
design/sycc_merge.sv
design/sycc_to_rgb_upsample_convert.sv
tb/sv/testbench.sv
